// ===== src/tgl_pkg.sv =====
// Shared types, constants and helper functions of the text glyph layout block.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package tgl_pkg;

   localparam int GLYPH_COUNT_DEFAULT = 128;
   localparam int TABLE_DEPTH_MAX     = 128;
   localparam int FIRST_GLYPH_CODE    = 33;
   localparam int TAB_SHIFT           = 3;

   // The queue pointers wrap on their own, so the depth is a power of two.
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_W   = 2;
   localparam int QUEUE_LEVEL_W = 3;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [7:0] LINE_HEIGHT_RESET = 8'd8;
   localparam logic [7:0] SPACE_WIDTH_RESET = 8'd8;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_AT    = 8'h40;
   localparam logic [7:0] CHAR_BAR   = 8'h7C;

   typedef enum logic [1:0] {
      MODE_LOAD  = 2'd0,
      MODE_BEGIN = 2'd1,
      MODE_CHAR  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      KIND_DRAW = 2'd0,
      KIND_BOX  = 2'd1,
      KIND_BAD  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CSR_LINE_HEIGHT   = 2'd0,
      CSR_SPACE_WIDTH   = 2'd1,
      CSR_GLYPH_SPACING = 2'd2,
      CSR_STOP_ON_BREAK = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      CLS_BEGIN,
      CLS_END,
      CLS_BREAK,
      CLS_TAB,
      CLS_SPACE,
      CLS_BAD,
      CLS_GLYPH
   } work_class_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic [6:0]         glyph_slot;
      logic [7:0]         glyph_width;
      logic [7:0]         glyph_height;
      logic signed [15:0] start_x;
      logic signed [15:0] start_y;
      logic [7:0]         char_code;
   } req_type;

   typedef struct packed {
      kind_type           result_kind;
      logic [6:0]         glyph_number;
      logic signed [15:0] draw_x;
      logic signed [15:0] draw_y;
      logic signed [15:0] box_width;
      logic [14:0]        box_height;
      logic [15:0]        chars_used;
   } rsp_type;

   typedef struct packed {
      logic [7:0]        line_height;
      logic [7:0]        space_width;
      logic signed [3:0] glyph_spacing;
      logic              stop_on_break;
   } cfg_type;

   // One classified word on its way from the front to the back.
   typedef struct packed {
      work_class_type     cls;
      logic [6:0]         glyph_number;
      logic signed [15:0] start_x;
      logic signed [15:0] start_y;
      logic [7:0]         glyph_width;
      logic [7:0]         glyph_height;
   } work_type;

   typedef struct packed {
      logic [QUEUE_LEVEL_W-1:0] level;
      logic                     empty;
   } queue_status_type;

   function automatic int table_depth(input int glyph_count);
      return (glyph_count < TABLE_DEPTH_MAX) ? glyph_count : TABLE_DEPTH_MAX;
   endfunction

   function automatic int addr_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

// ===== src/tgl_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Uses tgl_pkg for the address width helper.
`timescale 1ns / 1ps

module tgl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [tgl_pkg::addr_width(DEPTH)-1:0]    wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [tgl_pkg::addr_width(DEPTH)-1:0]    rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);
   import tgl_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/tgl_front.sv =====
// Front of the layout block: accepts request words, writes the glyph metrics
// table, classifies characters and reads the metrics. Uses tgl_pkg and tgl_ram.
`timescale 1ns / 1ps

module tgl_front #(
   parameter int GLYPH_COUNT = tgl_pkg::GLYPH_COUNT_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  tgl_pkg::req_type          req_data,
   input  tgl_pkg::queue_status_type queue_status,
   output logic                      push,
   output tgl_pkg::work_type         push_item
);
   import tgl_pkg::*;

   localparam int TABLE_DEPTH = table_depth(GLYPH_COUNT);
   localparam int ADDR_W      = addr_width(TABLE_DEPTH);

   logic              accept;
   logic              wr_en;
   logic              rd_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [15:0]       wr_data;
   logic [15:0]       rd_data;
   logic [7:0]        glyph_index;
   work_class_type    char_cls;
   logic              front_valid_ff;
   logic              front_valid_in;
   work_type          front_item_ff;
   work_type          front_item_in;

   // Every word held here or in the queue has a reserved queue slot.
   assign req_stall = (int'(queue_status.level) + int'(front_valid_ff)) >= QUEUE_DEPTH;
   assign accept    = req_valid && !req_stall;

   assign glyph_index = req_data.char_code - 8'(FIRST_GLYPH_CODE);

   always_comb begin
      priority if (req_data.char_code == CHAR_NUL) begin
         char_cls = CLS_END;
      end else if (req_data.char_code == CHAR_AT || req_data.char_code == CHAR_BAR) begin
         char_cls = CLS_BREAK;
      end else if (req_data.char_code == CHAR_TAB) begin
         char_cls = CLS_TAB;
      end else if (req_data.char_code == CHAR_SPACE) begin
         char_cls = CLS_SPACE;
      end else if (req_data.char_code < 8'(FIRST_GLYPH_CODE)
                   || int'(glyph_index) >= TABLE_DEPTH) begin
         char_cls = CLS_BAD;
      end else begin
         char_cls = CLS_GLYPH;
      end
   end

   assign wr_en   = accept && req_data.mode == MODE_LOAD
                    && int'(req_data.glyph_slot) < TABLE_DEPTH;
   assign wr_addr = req_data.glyph_slot[ADDR_W-1:0];
   assign wr_data = {req_data.glyph_width, req_data.glyph_height};
   assign rd_en   = accept && req_data.mode == MODE_CHAR && char_cls == CLS_GLYPH;
   assign rd_addr = glyph_index[ADDR_W-1:0];

   always_comb begin
      front_valid_in = accept && (req_data.mode == MODE_BEGIN
                                  || req_data.mode == MODE_CHAR);
      front_item_in              = '0;
      front_item_in.cls          = (req_data.mode == MODE_BEGIN) ? CLS_BEGIN : char_cls;
      front_item_in.glyph_number = glyph_index[6:0];
      front_item_in.start_x      = req_data.start_x;
      front_item_in.start_y      = req_data.start_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         front_item_ff <= front_item_in;
      end
   end

   tgl_ram #(
      .WIDTH(16),
      .DEPTH(TABLE_DEPTH)
   ) u_metrics (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // The metrics come out of the registered read in the cycle after the read, together with the held word.
   always_comb begin
      push      = front_valid_ff;
      push_item = front_item_ff;
      if (front_item_ff.cls == CLS_GLYPH) begin
         push_item.glyph_width  = rd_data[15:8];
         push_item.glyph_height = rd_data[7:0];
      end
   end

endmodule

// ===== src/tgl_queue.sv =====
// Short queue of classified words between the front and the back.
// Uses tgl_pkg for the word type and the queue depth.
`timescale 1ns / 1ps

module tgl_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  tgl_pkg::work_type         push_item,
   input  logic                      pop,
   output tgl_pkg::work_type         head_item,
   output tgl_pkg::queue_status_type status
);
   import tgl_pkg::*;

   work_type                 entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_in;
   logic [QUEUE_LEVEL_W-1:0] level_ff;
   logic [QUEUE_LEVEL_W-1:0] level_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   level_in = level_ff + 1'b1;
         2'b01:   level_in = level_ff - 1'b1;
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item    = entries_ff[rd_ptr_ff];
   assign status.level = level_ff;
   assign status.empty = (level_ff == '0);

endmodule

// ===== src/tgl_back.sv =====
// Back of the layout block: moves the pen, tracks lines and the box, and
// drives the result register. Uses tgl_pkg.
`timescale 1ns / 1ps

module tgl_back (
   input  logic                      clock,
   input  logic                      reset,
   input  tgl_pkg::cfg_type          cfg,
   input  tgl_pkg::queue_status_type queue_status,
   input  tgl_pkg::work_type         head_item,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output tgl_pkg::rsp_type          rsp_data
);
   import tgl_pkg::*;

   localparam logic signed [17:0] PEN_MAX = 18'sd32767;
   localparam logic signed [17:0] PEN_MIN = -18'sd32768;

   logic signed [15:0] origin_x_ff, origin_x_in;
   logic signed [15:0] origin_y_ff, origin_y_in;
   logic signed [15:0] pen_ff, pen_in;
   logic signed [15:0] widest_ff, widest_in;
   logic [15:0]        line_ff, line_in;
   logic [15:0]        counter_ff, counter_in;
   logic               frozen_ff, frozen_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               advance;
   logic               emit;
   rsp_type            result;
   logic signed [17:0] pen_addend;
   logic signed [17:0] pen_sum;
   logic signed [15:0] pen_sat;
   logic [16:0]        line_sum;
   logic [15:0]        draw_y;

   assign advance = !queue_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign pop     = advance;

   always_comb begin
      unique case (head_item.cls)
         CLS_TAB:   pen_addend = $signed(18'(cfg.space_width) << TAB_SHIFT);
         CLS_SPACE: pen_addend = $signed(18'(cfg.space_width));
         CLS_GLYPH: pen_addend = $signed(18'(head_item.glyph_width))
                                 + 18'(cfg.glyph_spacing);
         default:   pen_addend = '0;
      endcase
   end

   assign pen_sum  = 18'(pen_ff) + pen_addend;
   assign pen_sat  = (pen_sum > PEN_MAX) ? 16'sh7FFF :
                     (pen_sum < PEN_MIN) ? 16'sh8000 : pen_sum[15:0];
   assign line_sum = 17'(line_ff) + 17'(cfg.line_height);
   assign draw_y   = $unsigned(origin_y_ff) + line_ff + 16'(cfg.line_height)
                     - 16'(head_item.glyph_height);

   always_comb begin
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      pen_in      = pen_ff;
      widest_in   = widest_ff;
      line_in     = line_ff;
      counter_in  = counter_ff;
      frozen_in   = frozen_ff;
      emit        = 1'b0;
      result      = '0;

      if (advance) begin
         unique case (head_item.cls)
            CLS_BEGIN: begin
               origin_x_in = head_item.start_x;
               origin_y_in = head_item.start_y;
               pen_in      = '0;
               widest_in   = '0;
               line_in     = '0;
               counter_in  = '0;
               frozen_in   = 1'b0;
            end
            CLS_END: begin
               // A terminator reports the box even on a frozen layout.
               emit               = 1'b1;
               result.result_kind = KIND_BOX;
               result.box_width   = (pen_ff > widest_ff) ? pen_ff : widest_ff;
               result.box_height  = (line_sum > 17'd32767) ? 15'h7FFF : line_sum[14:0];
               result.chars_used  = counter_ff;
               frozen_in          = 1'b1;
            end
            default: begin
               if (!frozen_ff) begin
                  if (head_item.cls == CLS_BREAK && cfg.stop_on_break) begin
                     frozen_in = 1'b1;
                  end else begin
                     if (counter_ff != 16'hFFFF) begin
                        counter_in = counter_ff + 16'd1;
                     end
                     unique case (head_item.cls)
                        CLS_TAB, CLS_SPACE: begin
                           pen_in = pen_sat;
                        end
                        CLS_BREAK: begin
                           if (pen_ff > widest_ff) begin
                              widest_in = pen_ff;
                           end
                           line_in = line_sum[16] ? 16'hFFFF : line_sum[15:0];
                           pen_in  = '0;
                        end
                        CLS_BAD: begin
                           emit               = 1'b1;
                           result.result_kind = KIND_BAD;
                        end
                        CLS_GLYPH: begin
                           emit                = 1'b1;
                           result.result_kind  = KIND_DRAW;
                           result.glyph_number = head_item.glyph_number;
                           result.draw_x       = origin_x_ff + pen_ff;
                           result.draw_y       = draw_y;
                           pen_in              = pen_sat;
                        end
                        default: begin
                        end
                     endcase
                  end
               end
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = emit;
         rsp_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         pen_ff       <= '0;
         widest_ff    <= '0;
         line_ff      <= '0;
         counter_ff   <= '0;
         frozen_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         origin_x_ff  <= origin_x_in;
         origin_y_ff  <= origin_y_in;
         pen_ff       <= pen_in;
         widest_ff    <= widest_in;
         line_ff      <= line_in;
         counter_ff   <= counter_in;
         frozen_ff    <= frozen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== src/text_glyph_layout_top.sv =====
// Proportional text layout engine: one character word per clock cycle unless
// results stall. A word is taken in the cycle it is offered while the four-entry
// queue between the front (metrics table and classification) and the back (pen
// and box state) has room; a result is registered once its word passes the front
// register and a queue entry. The back sets the rate, updating the pen by the
// glyph width from the registered metrics RAM. The user must write configuration
// registers only while no word is in flight; the block does not enforce it. Top
// level; uses tgl_pkg, tgl_front, tgl_queue, tgl_back and tgl_ram.
`timescale 1ns / 1ps

module text_glyph_layout_top #(
   parameter int GLYPH_COUNT = tgl_pkg::GLYPH_COUNT_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  tgl_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output tgl_pkg::rsp_type               rsp_data,
   input  logic                           csr_write,
   input  logic [tgl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tgl_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tgl_pkg::*;

   cfg_type          cfg_ff;
   cfg_type          cfg_in;
   logic             push;
   work_type         push_item;
   logic             pop;
   work_type         head_item;
   queue_status_type queue_status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_LINE_HEIGHT:   cfg_in.line_height   = csr_wdata;
            CSR_SPACE_WIDTH:   cfg_in.space_width   = csr_wdata;
            CSR_GLYPH_SPACING: cfg_in.glyph_spacing = csr_wdata[3:0];
            CSR_STOP_ON_BREAK: cfg_in.stop_on_break = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_height   <= LINE_HEIGHT_RESET;
         cfg_ff.space_width   <= SPACE_WIDTH_RESET;
         cfg_ff.glyph_spacing <= '0;
         cfg_ff.stop_on_break <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tgl_front #(
      .GLYPH_COUNT(GLYPH_COUNT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .queue_status(queue_status),
      .push        (push),
      .push_item   (push_item)
   );

   tgl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_item(push_item),
      .pop      (pop),
      .head_item(head_item),
      .status   (queue_status)
   );

   tgl_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_status(queue_status),
      .head_item   (head_item),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the text glyph layout block: a directed table, then random strings.
// Every result word is checked against the directed table's value or a predictor of the pen, line and box state.
// Depends on tgl_pkg and text_glyph_layout_top.
`timescale 1ns / 1ps

module testbench;
   import tgl_pkg::*;

   localparam int GLYPHS = GLYPH_COUNT_DEFAULT;
   localparam int RANDOM_WORDS = 1550;
   localparam int PHASE_WORDS = 150;
   localparam int CYCLE_LIMIT = 600000;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int TEXT_PLAIN = 0;
   localparam int TEXT_WIDE = 1;
   localparam int TEXT_TALL = 2;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   typedef struct {
      req_type word;
      bit      typed;
      rsp_type want;
   } script_row_type;

   script_row_type script[$];
   rsp_type due_results[$];
   int failures = 0;
   int cycle_count = 0;
   int random_words = 0;
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;

   // Predictor state and its copy of the layout registers.
   logic [7:0] glyph_w[GLYPHS];
   logic [7:0] glyph_h[GLYPHS];
   bit glyph_loaded[GLYPHS];
   int org_x, org_y, pen, widest, line_off, used;
   bit frozen;
   int row_h, space_w, spacing;
   bit stop_brk;

   int ext_lh[6] = '{255, 0, 255, 1, 8, 0};
   int ext_sw[6] = '{255, 0, 255, 255, 8, 255};
   int ext_gs[6] = '{7, -8, -8, 7, 0, -1};
   bit ext_stop[6] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1};

   text_glyph_layout_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic int clip16(input int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic int pause_cycles(input bit calm);
      int n;
      n = $urandom_range(0, 11);
      return calm ? 0 : n;
   endfunction

   function automatic req_type noise_word();
      logic [95:0] bits;
      bits = {$urandom, $urandom, $urandom};
      return bits[$bits(req_type)-1:0];
   endfunction

   function automatic req_type plain_word(input logic [1:0] mode);
      req_type w;
      w = '0;
      w.mode = mode;
      return w;
   endfunction

   function automatic rsp_type drawn(input logic [6:0] g, input logic signed [15:0] x,
                                     input logic signed [15:0] y);
      rsp_type r;
      r = '0;
      r.result_kind = KIND_DRAW;
      r.glyph_number = g;
      r.draw_x = x;
      r.draw_y = y;
      return r;
   endfunction

   function automatic rsp_type boxed(input logic signed [15:0] bw, input logic [14:0] bh,
                                     input logic [15:0] n);
      rsp_type r;
      r = '0;
      r.result_kind = KIND_BOX;
      r.box_width = bw;
      r.box_height = bh;
      r.chars_used = n;
      return r;
   endfunction

   function automatic rsp_type rejected();
      rsp_type r;
      r = '0;
      r.result_kind = KIND_BAD;
      return r;
   endfunction

   // Applies one accepted word to the layout state and works out its result word, if any.
   task automatic lay_out_word(input req_type w, output bit emits, output rsp_type want);
      int code;
      int g;
      int bw;
      int bh;
      int dx;
      int dy;
      bit is_break;
      emits = 1'b0;
      want = '0;
      code = w.char_code;
      is_break = (w.char_code == CHAR_AT) || (w.char_code == CHAR_BAR);
      if (w.mode == MODE_LOAD) begin
         glyph_w[w.glyph_slot] = w.glyph_width;
         glyph_h[w.glyph_slot] = w.glyph_height;
         glyph_loaded[w.glyph_slot] = 1'b1;
      end else if (w.mode == MODE_BEGIN) begin
         org_x = $signed(w.start_x);
         org_y = $signed(w.start_y);
         pen = 0;
         line_off = 0;
         widest = 0;
         used = 0;
         frozen = 1'b0;
      end else if (w.mode == MODE_CHAR) begin
         if (w.char_code == CHAR_NUL) begin
            bw = (pen > widest) ? pen : widest;
            bh = line_off + row_h;
            if (bh > 32767) bh = 32767;
            want.result_kind = KIND_BOX;
            want.box_width = bw[15:0];
            want.box_height = bh[14:0];
            want.chars_used = used[15:0];
            frozen = 1'b1;
            emits = 1'b1;
         end else if (!frozen) begin
            if (is_break && stop_brk) begin
               frozen = 1'b1;
            end else begin
               if (used < 65535) used = used + 1;
               if (w.char_code == CHAR_TAB) begin
                  pen = clip16(pen + (space_w << TAB_SHIFT));
               end else if (w.char_code == CHAR_SPACE) begin
                  pen = clip16(pen + space_w);
               end else if (is_break) begin
                  if (pen > widest) widest = pen;
                  line_off = line_off + row_h;
                  if (line_off > 65535) line_off = 65535;
                  pen = 0;
               end else if (code < FIRST_GLYPH_CODE || code - FIRST_GLYPH_CODE >= GLYPHS) begin
                  want.result_kind = KIND_BAD;
                  emits = 1'b1;
               end else begin
                  g = code - FIRST_GLYPH_CODE;
                  dx = org_x + pen;
                  dy = org_y + line_off + row_h - int'(glyph_h[g]);
                  want.result_kind = KIND_DRAW;
                  want.glyph_number = g[6:0];
                  want.draw_x = dx[15:0];
                  want.draw_y = dy[15:0];
                  pen = clip16(pen + int'(glyph_w[g]) + spacing);
                  emits = 1'b1;
               end
            end
         end
      end
   endtask

   // Offers one word after a random gap, holds it until taken, then predicts its result.
   task automatic send_word(input req_type w, input bit typed, input rsp_type want);
      int gap;
      bit emits;
      rsp_type due;
      gap = pause_cycles(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      lay_out_word(w, emits, due);
      if (emits) due_results.push_back(typed ? want : due);
      if (w.mode != MODE_UNUSED) random_words++;
   endtask

   task automatic drain_results();
      int hold;
      forever begin
         hold = pause_cycles(rsp_calm);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   endtask

   // Waits until every expected word is back and the pipeline has emptied.
   task automatic settle();
      req_valid <= 1'b0;
      while (due_results.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic put_reg(input csr_index_type idx, input logic [7:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic set_layout_regs(input int lh, input int sw, input int gs, input bit stop);
      logic [7:0] v;
      put_reg(CSR_LINE_HEIGHT, lh[7:0]);
      put_reg(CSR_SPACE_WIDTH, sw[7:0]);
      // Bits above a narrow register are don't-care, so they get random values.
      v = 8'($urandom);
      v[3:0] = gs[3:0];
      put_reg(CSR_GLYPH_SPACING, v);
      v = 8'($urandom);
      v[0] = stop;
      put_reg(CSR_STOP_ON_BREAK, v);
      csr_write <= 1'b0;
      row_h = lh & 255;
      space_w = sw & 255;
      spacing = gs;
      stop_brk = stop;
   endtask

   task automatic plan(input req_type w, input bit typed, input rsp_type want);
      script_row_type r;
      r.word = w;
      r.typed = typed;
      r.want = want;
      script.push_back(r);
   endtask

   task automatic send_text_char(input int kind);
      req_type w;
      int roll;
      int g;
      int code;
      w = noise_word();
      w.mode = MODE_CHAR;
      roll = $urandom_range(0, 99);
      if (kind == TEXT_WIDE && roll < 50) begin
         w.char_code = CHAR_TAB;
      end else if (kind == TEXT_TALL && roll < 85) begin
         w.char_code = $urandom_range(0, 1) ? CHAR_AT : CHAR_BAR;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 50) begin
            g = $urandom_range(0, GLYPHS - 1);
            code = g + FIRST_GLYPH_CODE;
            w.char_code = code[7:0];
            // A glyph is never drawn from a slot that was never loaded.
            if (!glyph_loaded[g]) begin
               req_type ld;
               ld = noise_word();
               ld.mode = MODE_LOAD;
               ld.glyph_slot = g[6:0];
               send_word(ld, 1'b0, '0);
            end
         end else if (roll < 60) begin
            w.char_code = CHAR_SPACE;
         end else if (roll < 68) begin
            w.char_code = CHAR_TAB;
         end else if (roll < 76) begin
            w.char_code = $urandom_range(0, 1) ? CHAR_AT : CHAR_BAR;
         end else if (roll < 81) begin
            do code = $urandom_range(1, FIRST_GLYPH_CODE - 2); while (code == CHAR_TAB);
            w.char_code = code[7:0];
         end else if (roll < 86) begin
            code = $urandom_range(FIRST_GLYPH_CODE + GLYPHS, 255);
            w.char_code = code[7:0];
         end else if (roll < 90) begin
            w.char_code = (kind == TEXT_PLAIN) ? CHAR_NUL : CHAR_SPACE;
         end else if (roll < 95) begin
            w.mode = MODE_LOAD;
         end else begin
            w.mode = MODE_UNUSED;
         end
      end
      send_word(w, 1'b0, '0);
   endtask

   task automatic send_text_string(input int kind);
      req_type w;
      int n;
      int roll;
      req_calm = ($urandom_range(0, 3) == 0);
      rsp_calm = ($urandom_range(0, 3) == 0);
      w = noise_word();
      w.mode = MODE_BEGIN;
      send_word(w, 1'b0, '0);
      if (kind == TEXT_TALL) n = 330;
      else if (kind == TEXT_WIDE) n = $urandom_range(20, 40);
      else n = $urandom_range(0, 20);
      repeat (n) send_text_char(kind);
      roll = $urandom_range(0, 99);
      // Most strings end cleanly; some get words after the end, some are left open.
      if (roll < 85) begin
         w = noise_word();
         w.mode = MODE_CHAR;
         w.char_code = CHAR_NUL;
         send_word(w, 1'b0, '0);
         if (roll < 20) begin
            repeat ($urandom_range(1, 3)) send_text_char(TEXT_PLAIN);
            send_word(w, 1'b0, '0);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            $error("unexpected result word of kind %0d", rsp_data.result_kind);
            failures = failures + 1;
         end else begin
            rsp_type e;
            e = due_results.pop_front();
            if (rsp_data.result_kind !== e.result_kind) begin
               $error("result_kind: expected %0d, got %0d", e.result_kind, rsp_data.result_kind);
               failures = failures + 1;
            end
            if (rsp_data.glyph_number !== e.glyph_number) begin
               $error("glyph_number: expected %0d, got %0d", e.glyph_number,
                      rsp_data.glyph_number);
               failures = failures + 1;
            end
            if (rsp_data.draw_x !== e.draw_x) begin
               $error("draw_x: expected %0d, got %0d", e.draw_x, rsp_data.draw_x);
               failures = failures + 1;
            end
            if (rsp_data.draw_y !== e.draw_y) begin
               $error("draw_y: expected %0d, got %0d", e.draw_y, rsp_data.draw_y);
               failures = failures + 1;
            end
            if (rsp_data.box_width !== e.box_width) begin
               $error("box_width: expected %0d, got %0d", e.box_width, rsp_data.box_width);
               failures = failures + 1;
            end
            if (rsp_data.box_height !== e.box_height) begin
               $error("box_height: expected %0d, got %0d", e.box_height, rsp_data.box_height);
               failures = failures + 1;
            end
            if (rsp_data.chars_used !== e.chars_used) begin
               $error("chars_used: expected %0d, got %0d", e.chars_used, rsp_data.chars_used);
               failures = failures + 1;
            end
         end
      end
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("text_glyph_layout_top verification failed");
      $finish;
   end

   initial begin : stimulus
      req_type w;
      int i;
      int p;
      int phase_end;
      int gs;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      rsp_stall <= 1'b0;
      csr_write <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      for (i = 0; i < GLYPHS; i++) begin
         glyph_w[i] = '0;
         glyph_h[i] = '0;
         glyph_loaded[i] = 1'b0;
      end
      org_x = 0;
      org_y = 0;
      pen = 0;
      widest = 0;
      line_off = 0;
      used = 0;
      frozen = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      fork
         drain_results();
      join_none
      set_layout_regs(8, 8, 0, 1'b0);

      // Directed table under the reset register values.
      w = plain_word(MODE_LOAD);
      w.glyph_slot = 7'd0;
      w.glyph_width = 8'd255;
      w.glyph_height = 8'd255;
      plan(w, 1'b0, '0);
      w.glyph_slot = 7'd127;
      w.glyph_width = 8'd0;
      w.glyph_height = 8'd0;
      plan(w, 1'b0, '0);
      w.glyph_slot = 7'd1;
      w.glyph_width = 8'd5;
      w.glyph_height = 8'd3;
      plan(w, 1'b0, '0);
      plan('1, 1'b0, '0);
      w = plain_word(MODE_BEGIN);
      w.start_x = 16'sh8000;
      w.start_y = 16'sh7FFF;
      plan(w, 1'b0, '0);
      w = plain_word(MODE_CHAR);
      w.char_code = 8'd33;
      plan(w, 1'b1, drawn(7'd0, 16'sh8000, 16'sd32520));
      w.char_code = 8'd34;
      plan(w, 1'b1, drawn(7'd1, 16'sh80FF, 16'sh8004));
      w.char_code = CHAR_TAB;
      plan(w, 1'b0, '0);
      w.char_code = CHAR_SPACE;
      plan(w, 1'b0, '0);
      w.char_code = 8'd1;
      plan(w, 1'b1, rejected());
      w.char_code = 8'd255;
      plan(w, 1'b1, rejected());
      w.char_code = 8'd161;
      plan(w, 1'b1, rejected());
      w.char_code = 8'd31;
      plan(w, 1'b1, rejected());
      w.char_code = CHAR_AT;
      plan(w, 1'b0, '0);
      w.char_code = 8'd160;
      plan(w, 1'b0, '0);
      w.char_code = CHAR_NUL;
      plan(w, 1'b1, boxed(16'sd332, 15'd16, 16'd10));
      w.char_code = 8'd33;
      plan(w, 1'b0, '0);
      w.char_code = CHAR_NUL;
      plan(w, 1'b1, boxed(16'sd332, 15'd16, 16'd10));
      w = '1;
      w.mode = MODE_BEGIN;
      w.start_x = '0;
      w.start_y = '0;
      plan(w, 1'b0, '0);
      w = plain_word(MODE_CHAR);
      w.char_code = CHAR_BAR;
      plan(w, 1'b0, '0);
      w.char_code = CHAR_TAB;
      plan(w, 1'b0, '0);
      w.char_code = CHAR_NUL;
      plan(w, 1'b1, boxed(16'sd64, 15'd16, 16'd2));
      foreach (script[k]) send_word(script[k].word, script[k].typed, script[k].want);
      settle();

      // Random strings, one register setting per phase, extremes first.
      random_words = 0;
      p = 0;
      while (random_words < RANDOM_WORDS) begin
         if (p < 6) begin
            set_layout_regs(ext_lh[p], ext_sw[p], ext_gs[p], ext_stop[p]);
         end else begin
            gs = $urandom_range(0, 15);
            gs = gs - 8;
            set_layout_regs($urandom_range(0, 255), $urandom_range(0, 255), gs,
                            1'($urandom_range(0, 1)));
         end
         // Enough line breaks at full line height saturate both the box and the line offset.
         if (row_h == 255 && !stop_brk) send_text_string(TEXT_TALL);
         phase_end = random_words + PHASE_WORDS;
         while (random_words < phase_end && random_words < RANDOM_WORDS) begin
            send_text_string(($urandom_range(0, 99) < 15) ? TEXT_WIDE : TEXT_PLAIN);
         end
         settle();
         p++;
      end

      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("text_glyph_layout_top verification clean");
      end else begin
         $display("text_glyph_layout_top verification failed");
      end
      $finish;
   end

endmodule
